FILE: rtl/core/amob_pkg.sv
package amob_pkg;

    localparam int unsigned PIX_W    = 32;
    localparam int unsigned CH_W     = 8;
    localparam int unsigned N_CH     = PIX_W / CH_W;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;

    // blend modes; the spare code falls back to general
    localparam logic [1:0] MODE_GENERAL = 2'd0;
    localparam logic [1:0] MODE_OPAQUE  = 2'd1;
    localparam logic [1:0] MODE_ALPHA   = 2'd2;

    localparam logic [PIX_W-1:0] COLOR_RESET = 32'hffff_ffff;
    localparam logic [CH_W-1:0]  CH_MAX      = 8'hff;

    typedef struct packed {
        logic [PIX_W-1:0] color;
        logic             opaque;
        logic             alpha_only;
    } t_blend_ctl;

    // word leaving the colour scale stage
    typedef struct packed {
        logic [PIX_W-1:0] sc;
        logic [PIX_W-1:0] dst;
        logic             opaque;
        logic             last;
    } t_sc_word;

    // word leaving the destination weight stage
    typedef struct packed {
        logic [PIX_W-1:0] sc;
        logic [PIX_W-1:0] dw;
        logic             opaque;
        logic             last;
    } t_wt_word;

endpackage

FILE: rtl/core/amob_scale.sv
module amob_scale (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  amob_pkg::t_blend_ctl           i_ctl,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [amob_pkg::PIX_W-1:0]     i_src,
    input  logic [amob_pkg::PIX_W-1:0]     i_dst,
    input  logic                           i_last,
    output logic                           o_valid,
    input  logic                           i_ready,
    output amob_pkg::t_sc_word             o_word
);
    import amob_pkg::*;

    logic     r_valid;
    t_sc_word r_word;
    t_sc_word n_word;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // sc = (s*c + 255) >> 8, or s*(ca+1) >> 8 in alpha-only mode
    always_comb begin
        logic [CH_W:0]     k;
        logic [2*CH_W-1:0] prod;
        n_word        = '0;
        n_word.dst    = i_dst;
        n_word.opaque = i_ctl.opaque;
        n_word.last   = i_last;
        for (int i = 0; i < N_CH; i++) begin
            if (i_ctl.alpha_only) begin
                k    = {1'b0, i_ctl.color[PIX_W-1 -: CH_W]} + 9'd1;
                prod = {8'd0, i_src[i*CH_W +: CH_W]} * {7'd0, k};
            end else begin
                k    = {1'b0, i_ctl.color[i*CH_W +: CH_W]};
                prod = {8'd0, i_src[i*CH_W +: CH_W]} * {7'd0, k} + {8'd0, CH_MAX};
            end
            n_word.sc[i*CH_W +: CH_W] = prod[2*CH_W-1:CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

FILE: rtl/core/amob_weigh.sv
module amob_weigh (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  amob_pkg::t_sc_word   i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output amob_pkg::t_wt_word   o_word
);
    import amob_pkg::*;

    logic     r_valid;
    t_wt_word r_word;
    t_wt_word n_word;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // destination weighted by 256 - scaled alpha
    always_comb begin
        logic [CH_W:0]     w;
        logic [2*CH_W-1:0] prod;
        n_word        = '0;
        n_word.sc     = i_word.sc;
        n_word.opaque = i_word.opaque;
        n_word.last   = i_word.last;
        w = 9'd256 - {1'b0, i_word.sc[PIX_W-1 -: CH_W]};
        for (int i = 0; i < N_CH; i++) begin
            prod = {8'd0, i_word.dst[i*CH_W +: CH_W]} * {7'd0, w};
            n_word.dw[i*CH_W +: CH_W] = prod[2*CH_W-1:CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

FILE: rtl/core/amob_sum.sv
module amob_sum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  amob_pkg::t_wt_word           i_word,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [amob_pkg::PIX_W-1:0]   o_pixel,
    output logic                         o_last
);
    import amob_pkg::*;

    logic             r_valid;
    logic [PIX_W-1:0] r_pixel;
    logic             r_last;
    logic [PIX_W-1:0] n_pixel;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;

    always_comb begin
        logic [CH_W:0] v;
        n_pixel = '0;
        for (int i = 0; i < N_CH; i++) begin
            v = {1'b0, i_word.sc[i*CH_W +: CH_W]} + {1'b0, i_word.dw[i*CH_W +: CH_W]};
            n_pixel[i*CH_W +: CH_W] = v[CH_W] ? CH_MAX : v[CH_W-1:0];
        end
        // opaque: full alpha over the scaled source, destination unused
        if (i_word.opaque) begin
            n_pixel = {CH_MAX, i_word.sc[PIX_W-CH_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pixel <= n_pixel;
            r_last  <= i_word.last;
        end
    end

endmodule

FILE: rtl/core/argb_color_modulated_over_blend.sv
// Premultiplied ARGB8888 source-over blend with colour modulation.
// Input channel: i_in_valid / o_in_ready carry one word of i_src_pixel,
// i_dst_pixel and i_span_last. Output channel: o_out_valid / i_out_ready
// carry o_out_pixel and o_out_last, one word per input word, in order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and
// i_cfg_data; index 0 is the modulation colour, index 1 the blend mode.
// The port is always ready; write only while no pixel is in flight.
// Each word passes through three register stages in order: colour scale,
// destination weight, saturating sum.
// Throughput is one pixel per cycle with no bubbles while i_out_ready is high.
// When the receiver stalls, words pile up in the stages; o_in_ready falls
// only once all three stages hold a word, and nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline, sets the colour
// to all ones and the mode to general.
module argb_color_modulated_over_blend (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [amob_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [amob_pkg::PIX_W-1:0]            i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [amob_pkg::PIX_W-1:0]            i_src_pixel,
    input  logic [amob_pkg::PIX_W-1:0]            i_dst_pixel,
    input  logic                                  i_span_last,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [amob_pkg::PIX_W-1:0]            o_out_pixel,
    output logic                                  o_out_last
);
    import amob_pkg::*;

    logic [PIX_W-1:0] r_color;
    logic [1:0]       r_mode;
    t_blend_ctl       ctl;

    logic     sc_valid, sc_ready;
    t_sc_word sc_word;
    logic     wt_valid, wt_ready;
    t_wt_word wt_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
            r_mode  <= MODE_GENERAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COLOR: r_color <= i_cfg_data;
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ctl.color      = r_color;
        ctl.opaque     = 1'b0;
        ctl.alpha_only = 1'b0;
        case (r_mode)
            MODE_OPAQUE: ctl.opaque     = 1'b1;
            MODE_ALPHA:  ctl.alpha_only = 1'b1;
            default: ;
        endcase
    end

    amob_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_src   (i_src_pixel),
        .i_dst   (i_dst_pixel),
        .i_last  (i_span_last),
        .o_valid (sc_valid),
        .i_ready (sc_ready),
        .o_word  (sc_word)
    );

    amob_weigh u_weigh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sc_valid),
        .o_ready (sc_ready),
        .i_word  (sc_word),
        .o_valid (wt_valid),
        .i_ready (wt_ready),
        .o_word  (wt_word)
    );

    amob_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (wt_valid),
        .o_ready (wt_ready),
        .i_word  (wt_word),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_pixel (o_out_pixel),
        .o_last  (o_out_last)
    );

`ifndef SYNTH
    // back-pressure only reaches the input once every stage is full
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && wt_valid && sc_valid))
        else $error("input stalled while a stage is empty");

    // opaque mode always writes full alpha
    a_opaque_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_mode == MODE_OPAQUE) |-> (o_out_pixel[PIX_W-1 -: CH_W] == CH_MAX))
        else $error("opaque mode result without full alpha");

    // a word held in the weight stage moves on as soon as the output frees
    a_weigh_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wt_valid && !o_out_valid) |=> o_out_valid)
        else $error("weighted word not advanced into empty output stage");
`endif

endmodule
